/* src/efp_pkg.sv */
// ----------------------------------------------------------------------------
// EEG frame parser package
// Shared widths, frame offsets, header bytes, register indexes, controller
// states and the command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package efp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned GAIN_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Full scale in microvolts; the scaled magnitude also fits this width.
  localparam int unsigned SCALE_W = 23;
  localparam int unsigned PROD_W  = SAMPLE_W + SCALE_W;
  localparam logic [SCALE_W-1:0] UV_FULL_SCALE = 23'd4500000;
  localparam int unsigned DIV_CNT_W = $clog2(SCALE_W);

  localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd12;
  localparam logic [GAIN_W-1:0] GAIN_MIN   = 8'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_GAIN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_GAIN = 1'b1;

  localparam int unsigned HDR_LEN = 4;
  localparam logic [BYTE_W-1:0] HDR_BYTES [HDR_LEN] = '{8'h41, 8'h49, 8'h52, 8'h90};

  localparam logic [POS_W-1:0] POS_HDR_END   = 8'd4;
  localparam logic [POS_W-1:0] POS_CMD_LO    = 8'd4;
  localparam logic [POS_W-1:0] POS_CMD_HI    = 8'd5;
  localparam logic [POS_W-1:0] POS_LEN_LO    = 8'd6;
  localparam logic [POS_W-1:0] POS_LEN_HI    = 8'd7;
  localparam logic [POS_W-1:0] POS_ORD_HI    = 8'd8;
  localparam logic [POS_W-1:0] POS_ORD_MID   = 8'd9;
  localparam logic [POS_W-1:0] POS_ORD_LO    = 8'd10;
  localparam logic [POS_W-1:0] POS_BAT_LO    = 8'd11;
  localparam logic [POS_W-1:0] POS_BAT_HI    = 8'd12;
  localparam logic [POS_W-1:0] POS_EEG_FIRST = 8'd73;
  localparam logic [POS_W-1:0] POS_EEG_LAST  = 8'd142;
  localparam logic [POS_W-1:0] POS_OFF       = 8'd143;
  localparam logic [POS_W-1:0] POS_GRAV_LO   = 8'd160;
  localparam logic [POS_W-1:0] POS_GRAV_MID  = 8'd161;
  localparam logic [POS_W-1:0] POS_GRAV_HI   = 8'd162;
  localparam logic [POS_W-1:0] POS_CHK_LO    = 8'd185;
  localparam logic [POS_W-1:0] POS_CHK_HI    = 8'd186;
  localparam logic [POS_W-1:0] POS_MIN_OK    = 8'd7;
  localparam logic [POS_W-1:0] POS_MAX       = 8'd255;

  localparam int unsigned WIN_BYTES = 6;
  localparam logic [2:0] WIN_EVENT_SLOT = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_DIV1,
    ST_MUL2,
    ST_DIV2,
    ST_SAMPLE,
    ST_SUMMARY
  } efp_state_t;

  typedef struct packed {
    logic in_ready;
    logic start_first;
    logic start_second;
    logic store_first;
    logic store_second;
    logic load_sample;
    logic load_summary;
  } efp_cmd_t;

  typedef struct packed {
    logic byte_valid;
    logic byte_last;
    logic byte_sample;
    logic div_done;
    logic out_free;
  } efp_stat_t;

endpackage

/* src/efp_in_if.sv */
// ----------------------------------------------------------------------------
// EEG frame parser input channel
// Valid/ready channel carrying one frame byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface efp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* src/efp_out_if.sv */
// ----------------------------------------------------------------------------
// EEG frame parser result channel
// Valid/ready channel carrying one sample record or one frame summary.
// ----------------------------------------------------------------------------
interface efp_out_if;
  logic               valid;
  logic               ready;
  logic               record_kind;
  logic signed [23:0] first_uv;
  logic signed [23:0] second_uv;
  logic [7:0]         event_mark;
  logic [15:0]        command_word;
  logic [15:0]        length_word;
  logic [23:0]        order_number;
  logic [15:0]        battery_level;
  logic               electrode_off;
  logic [23:0]        gravity_value;
  logic [15:0]        check_word;
  logic               frame_ok;

  modport source (
    output valid, output record_kind, output first_uv, output second_uv,
    output event_mark, output command_word, output length_word,
    output order_number, output battery_level, output electrode_off,
    output gravity_value, output check_word, output frame_ok, input ready
  );
  modport sink (
    input valid, input record_kind, input first_uv, input second_uv,
    input event_mark, input command_word, input length_word,
    input order_number, input battery_level, input electrode_off,
    input gravity_value, input check_word, input frame_ok, output ready
  );
endinterface

/* src/eeg_frame_parser.sv */
// ----------------------------------------------------------------------------
// EEG frame parser
// Parses a byte-serial EEG frame into scaled sample records and a summary.
// ----------------------------------------------------------------------------
// Usage: frame bytes enter on in_chan, one beat per byte, with last_byte set on
// the final byte of the frame. Each completed seven-byte EEG window after a
// good header yields one sample record on out_chan; the last byte yields one
// frame summary record. Gains are written on the cfg port while the block is
// idle; a gain of zero acts as one.
// Throughput: bytes that cause no record are taken one per cycle. The seventh
// byte of a window starts both channel scalings, which run in turn through one
// shared restoring divider that settles one quotient bit per cycle (23 bits
// per channel). No further byte is taken until that sample record has entered
// the output register, nor after the last byte until its summary has.
// Reset: synchronous, active low; it clears the frame state and the output
// valid flag and loads both gains with 12.
// Stall: results sit in an output register. Bytes that cause no record keep
// flowing while a record waits there; a byte that causes a record is accepted
// and its record waits inside until the output register frees up.
// ----------------------------------------------------------------------------
module eeg_frame_parser
  import efp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_wdata,
  efp_in_if.sink               in_chan,
  efp_out_if.source            out_chan
);

  // The controller only sees status and only drives commands; all data stays
  // in the datapath.
  efp_cmd_t  cmd;
  efp_stat_t stat;

  efp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  efp_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

endmodule

/* src/efp_divider.sv */
// ----------------------------------------------------------------------------
// EEG frame parser divider
// Restoring divider, one quotient bit per cycle, shared by both channels.
// ----------------------------------------------------------------------------
module efp_divider
  import efp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SCALE_W-1:0] dividend,
  input  logic [GAIN_W-1:0]  divisor,
  output logic               done,
  output logic [SCALE_W-1:0] quotient
);

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(SCALE_W - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [SCALE_W-1:0]   quo_r;
  logic [GAIN_W-1:0]    rem_r;
  logic [GAIN_W-1:0]    dvs_r;
  logic [GAIN_W:0]      trial;
  logic [GAIN_W:0]      diff;
  logic                 fits;

  always_comb begin
    trial = {rem_r, quo_r[SCALE_W-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[GAIN_W-1:0] : trial[GAIN_W-1:0];
      quo_r <= {quo_r[SCALE_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* src/efp_datapath.sv */
// ----------------------------------------------------------------------------
// EEG frame parser datapath
// Byte position, header check, field capture, window store, scaling
// multiplier with shared divider, gain registers and the output register.
// ----------------------------------------------------------------------------
module efp_datapath
  import efp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_wdata,
  input  efp_cmd_t             cmd,
  output efp_stat_t            stat,
  efp_in_if.sink               in_chan,
  efp_out_if.source            out_chan
);

  logic [POS_W-1:0]  pos_r;
  logic              hdr_good_r;
  logic [2:0]        slot_r;
  logic [BYTE_W-1:0] win_r [WIN_BYTES];
  logic [15:0]       cmd_word_r;
  logic [15:0]       len_word_r;
  logic [23:0]       order_r;
  logic [15:0]       battery_r;
  logic              off_r;
  logic [23:0]       gravity_r;
  logic [15:0]       check_r;
  logic [BYTE_W-1:0] event_r;
  logic              sum_ok_r;
  logic              sum_chk_r;
  logic [GAIN_W-1:0] gain1_r;
  logic [GAIN_W-1:0] gain2_r;
  logic              neg_r;
  logic signed [SAMPLE_W-1:0] uv1_r;

  logic                out_valid_r;
  logic                out_kind_r;
  logic signed [23:0]  out_uv1_r;
  logic signed [23:0]  out_uv2_r;
  logic [7:0]          out_event_r;
  logic [15:0]         out_cmd_r;
  logic [15:0]         out_len_r;
  logic [23:0]         out_order_r;
  logic [15:0]         out_bat_r;
  logic                out_off_r;
  logic [23:0]         out_grav_r;
  logic [15:0]         out_chk_r;
  logic                out_ok_r;

  logic                accept;
  logic [BYTE_W-1:0]   b;
  logic                hdr_good_nxt;
  logic                in_eeg;
  logic [SAMPLE_W-1:0] raw;
  logic                raw_neg;
  logic [SAMPLE_W-1:0] mag;
  logic [PROD_W-1:0]   prod;
  logic [GAIN_W-1:0]   gain_sel;
  logic [GAIN_W-1:0]   divisor;
  logic                div_start;
  logic                div_done;
  logic [SCALE_W-1:0]  quotient;
  logic signed [SAMPLE_W-1:0] uv_signed;

  assign accept = in_chan.valid && cmd.in_ready;
  assign b      = in_chan.data_byte;

  always_comb begin
    hdr_good_nxt = hdr_good_r;
    if (pos_r < POS_HDR_END && b != HDR_BYTES[pos_r[1:0]]) begin
      hdr_good_nxt = 1'b0;
    end
    in_eeg = pos_r inside {[POS_EEG_FIRST:POS_EEG_LAST]};
  end

  assign in_chan.ready = cmd.in_ready;

  assign stat.byte_valid  = in_chan.valid;
  assign stat.byte_last   = in_chan.last_byte;
  assign stat.byte_sample = in_eeg && (slot_r == WIN_EVENT_SLOT) && hdr_good_r &&
                            !in_chan.last_byte;
  assign stat.div_done    = div_done;
  assign stat.out_free    = !out_valid_r || out_chan.ready;

  // Frame state; cleared at reset and when the summary leaves for the output.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_summary) begin
      pos_r      <= '0;
      hdr_good_r <= 1'b1;
      slot_r     <= '0;
      for (int i = 0; i < WIN_BYTES; i++) win_r[i] <= '0;
      cmd_word_r <= '0;
      len_word_r <= '0;
      order_r    <= '0;
      battery_r  <= '0;
      off_r      <= 1'b0;
      gravity_r  <= '0;
      check_r    <= '0;
      sum_ok_r   <= 1'b0;
      sum_chk_r  <= 1'b0;
    end else if (accept) begin
      hdr_good_r <= hdr_good_nxt;
      case (pos_r)
        POS_CMD_LO:   cmd_word_r[7:0]   <= b;
        POS_CMD_HI:   cmd_word_r[15:8]  <= b;
        POS_LEN_LO:   len_word_r[7:0]   <= b;
        POS_LEN_HI:   len_word_r[15:8]  <= b;
        POS_ORD_HI:   order_r[23:16]    <= b;
        POS_ORD_MID:  order_r[15:8]     <= b;
        POS_ORD_LO:   order_r[7:0]      <= b;
        POS_BAT_LO:   battery_r[7:0]    <= b;
        POS_BAT_HI:   battery_r[15:8]   <= b;
        POS_OFF:      off_r             <= (b != '0);
        POS_GRAV_LO:  gravity_r[7:0]    <= b;
        POS_GRAV_MID: gravity_r[15:8]   <= b;
        POS_GRAV_HI:  gravity_r[23:16]  <= b;
        POS_CHK_LO:   check_r[7:0]      <= b;
        POS_CHK_HI:   check_r[15:8]     <= b;
        default: ;
      endcase
      if (in_eeg) begin
        if (slot_r != WIN_EVENT_SLOT) begin
          win_r[slot_r] <= b;
          slot_r        <= slot_r + 1'b1;
        end else begin
          slot_r <= '0;
        end
      end
      if (in_chan.last_byte) begin
        sum_ok_r  <= hdr_good_nxt && (pos_r >= POS_MIN_OK);
        sum_chk_r <= (pos_r >= POS_CHK_HI);
      end else if (pos_r != POS_MAX) begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) event_r <= b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain1_r <= GAIN_RESET;
      gain2_r <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_GAIN:  gain1_r <= cfg_wdata;
        CFG_SECOND_GAIN: gain2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Scaling: |raw| * full scale, drop 23 bits, then divide by the gain.
  // Truncating the magnitude and restoring the sign rounds toward zero.
  always_comb begin
    if (cmd.start_second) begin
      raw      = {win_r[5], win_r[4], win_r[3]};
      gain_sel = gain2_r;
    end else begin
      raw      = {win_r[2], win_r[1], win_r[0]};
      gain_sel = gain1_r;
    end
    raw_neg = raw[SAMPLE_W-1];
    mag     = raw_neg ? (~raw + 1'b1) : raw;
    prod    = PROD_W'(mag) * PROD_W'(UV_FULL_SCALE);
    divisor = (gain_sel == '0) ? GAIN_MIN : gain_sel;
  end

  assign div_start = cmd.start_first || cmd.start_second;

  efp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod[PROD_W-2 -: SCALE_W]),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    if (neg_r) uv_signed = -$signed({1'b0, quotient});
    else       uv_signed = $signed({1'b0, quotient});
  end

  always_ff @(posedge clk) begin
    if (div_start) neg_r <= raw_neg;
    if (cmd.store_first) uv1_r <= uv_signed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_sample || cmd.load_summary) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      out_kind_r  <= 1'b0;
      out_uv1_r   <= uv1_r;
      out_uv2_r   <= uv_signed;
      out_event_r <= event_r;
      out_cmd_r   <= '0;
      out_len_r   <= '0;
      out_order_r <= '0;
      out_bat_r   <= '0;
      out_off_r   <= 1'b0;
      out_grav_r  <= '0;
      out_chk_r   <= '0;
      out_ok_r    <= 1'b0;
    end else if (cmd.load_summary) begin
      out_kind_r  <= 1'b1;
      out_uv1_r   <= '0;
      out_uv2_r   <= '0;
      out_event_r <= '0;
      out_cmd_r   <= sum_ok_r ? cmd_word_r : '0;
      out_len_r   <= sum_ok_r ? len_word_r : '0;
      out_order_r <= sum_ok_r ? order_r : '0;
      out_bat_r   <= sum_ok_r ? battery_r : '0;
      out_off_r   <= sum_ok_r && off_r;
      out_grav_r  <= sum_ok_r ? gravity_r : '0;
      out_chk_r   <= (sum_ok_r && sum_chk_r) ? check_r : '0;
      out_ok_r    <= sum_ok_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.record_kind   = out_kind_r;
  assign out_chan.first_uv      = out_uv1_r;
  assign out_chan.second_uv     = out_uv2_r;
  assign out_chan.event_mark    = out_event_r;
  assign out_chan.command_word  = out_cmd_r;
  assign out_chan.length_word   = out_len_r;
  assign out_chan.order_number  = out_order_r;
  assign out_chan.battery_level = out_bat_r;
  assign out_chan.electrode_off = out_off_r;
  assign out_chan.gravity_value = out_grav_r;
  assign out_chan.check_word    = out_chk_r;
  assign out_chan.frame_ok      = out_ok_r;

endmodule

/* src/efp_ctrl.sv */
// ----------------------------------------------------------------------------
// EEG frame parser controller
// Sequences byte intake, the two channel divisions and the record loads.
// ----------------------------------------------------------------------------
module efp_ctrl
  import efp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  efp_stat_t stat,
  output efp_cmd_t  cmd
);

  efp_state_t state_r;
  efp_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.byte_valid) begin
          if (stat.byte_last)        state_nxt = ST_SUMMARY;
          else if (stat.byte_sample) state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.start_first = 1'b1;
        state_nxt       = ST_DIV1;
      end
      ST_DIV1: begin
        if (stat.div_done) begin
          cmd.store_first = 1'b1;
          state_nxt       = ST_MUL2;
        end
      end
      ST_MUL2: begin
        cmd.start_second = 1'b1;
        state_nxt        = ST_DIV2;
      end
      ST_DIV2: begin
        // The second quotient goes straight into the output register if it is free, else waits.
        if (stat.div_done) begin
          if (stat.out_free) begin
            cmd.load_sample = 1'b1;
            state_nxt       = ST_IDLE;
          end else begin
            cmd.store_second = 1'b1;
            state_nxt        = ST_SAMPLE;
          end
        end
      end
      ST_SAMPLE: begin
        if (stat.out_free) begin
          cmd.load_sample = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_SUMMARY: begin
        if (stat.out_free) begin
          cmd.load_summary = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* src/efp_checker.sv */
// ----------------------------------------------------------------------------
// EEG frame parser port checker
// Assertions on the top-level ports, bound to every parser instance.
// ----------------------------------------------------------------------------
module efp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic        kind,
  input logic [23:0] first_uv,
  input logic [23:0] second_uv,
  input logic [7:0]  event_mark,
  input logic [15:0] command_word,
  input logic [15:0] check_word,
  input logic        electrode_off,
  input logic        frame_ok
);

  // A stalled beat keeps its record.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(first_uv) &&
      $stable(kind) && $stable(command_word))
    else $error("stalled output beat changed");

  // The last byte closes the frame, so no byte is taken right after it.
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("byte accepted right after last byte");

  a_sample_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !kind |-> command_word == 16'd0 && check_word == 16'd0 &&
      !frame_ok && !electrode_off)
    else $error("sample record carries summary fields");

  a_bad_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind && !frame_ok |-> command_word == 16'd0 &&
      check_word == 16'd0 && first_uv == 24'd0 && second_uv == 24'd0 &&
      event_mark == 8'd0 && !electrode_off)
    else $error("failed frame summary has nonzero fields");

endmodule

bind eeg_frame_parser efp_checker u_efp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_last       (in_chan.last_byte),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .kind          (out_chan.record_kind),
  .first_uv      (out_chan.first_uv),
  .second_uv     (out_chan.second_uv),
  .event_mark    (out_chan.event_mark),
  .command_word  (out_chan.command_word),
  .check_word    (out_chan.check_word),
  .electrode_off (out_chan.electrode_off),
  .frame_ok      (out_chan.frame_ok)
);

/* dv/efp_frame_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// EEG frame parser record checker
// Watches the byte, record and gain ports, predicts every sample and summary
// record from the accepted bytes, and compares the records the block delivers.
// ----------------------------------------------------------------------------
module efp_frame_checker
  import efp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_wdata,
  efp_in_if                    in_mon,
  efp_out_if                   out_mon,
  output int                   fail_count,
  output int                   pending,
  output int                   sample_count,
  output int                   summary_count
);

  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;
  localparam int   WIN_LEN      = 7;
  localparam int   SHOWN_MAX    = 10;

  typedef struct packed {
    logic        record_kind;
    logic [23:0] first_uv;
    logic [23:0] second_uv;
    logic [7:0]  event_mark;
    logic [15:0] command_word;
    logic [15:0] length_word;
    logic [23:0] order_number;
    logic [15:0] battery_level;
    logic        electrode_off;
    logic [23:0] gravity_value;
    logic [15:0] check_word;
    logic        frame_ok;
  } efp_record_t;

  efp_record_t       expected_records [$];

  logic [GAIN_W-1:0] gain_first;
  logic [GAIN_W-1:0] gain_second;
  logic [POS_W-1:0]  byte_pos;
  logic              header_ok;
  logic [7:0]        win_bytes [WIN_BYTES];
  logic [15:0]       cmd_acc;
  logic [15:0]       len_acc;
  logic [23:0]       order_acc;
  logic [15:0]       battery_acc;
  logic              off_acc;
  logic [23:0]       gravity_acc;
  logic [15:0]       check_acc;

  int n_fail;
  int n_sample;
  int n_summary;

  task automatic clear_frame_state();
    byte_pos    = '0;
    header_ok   = 1'b1;
    for (int i = 0; i < WIN_BYTES; i++) win_bytes[i] = '0;
    cmd_acc     = '0;
    len_acc     = '0;
    order_acc   = '0;
    battery_acc = '0;
    off_acc     = 1'b0;
    gravity_acc = '0;
    check_acc   = '0;
  endtask

  // Signed 24-bit raw count to microvolts, truncated toward zero. A gain of
  // zero divides as a gain of one.
  function automatic logic [23:0] scale_to_uv(logic [23:0] raw, logic [GAIN_W-1:0] gain);
    longint signed_raw;
    longint divisor;
    longint quotient;
    signed_raw = longint'($signed(raw));
    divisor    = longint'((gain == '0) ? GAIN_MIN : gain) * (longint'(1) << (SAMPLE_W - 1));
    quotient   = (signed_raw * longint'(UV_FULL_SCALE)) / divisor;
    return quotient[23:0];
  endfunction

  task automatic parse_frame_byte(input logic [7:0] b, input logic last);
    logic [POS_W-1:0] p;
    int               slot;
    logic             sample_due;
    efp_record_t      rec;
    p          = byte_pos;
    sample_due = 1'b0;
    rec        = '0;

    if (p < HDR_LEN && b != HDR_BYTES[p[1:0]]) header_ok = 1'b0;

    case (p)
      POS_CMD_LO:   cmd_acc[7:0]       = b;
      POS_CMD_HI:   cmd_acc[15:8]      = b;
      POS_LEN_LO:   len_acc[7:0]       = b;
      POS_LEN_HI:   len_acc[15:8]      = b;
      POS_ORD_HI:   order_acc[23:16]   = b;
      POS_ORD_MID:  order_acc[15:8]    = b;
      POS_ORD_LO:   order_acc[7:0]     = b;
      POS_BAT_LO:   battery_acc[7:0]   = b;
      POS_BAT_HI:   battery_acc[15:8]  = b;
      POS_OFF:      off_acc            = (b != 8'd0);
      POS_GRAV_LO:  gravity_acc[7:0]   = b;
      POS_GRAV_MID: gravity_acc[15:8]  = b;
      POS_GRAV_HI:  gravity_acc[23:16] = b;
      POS_CHK_LO:   check_acc[7:0]     = b;
      POS_CHK_HI:   check_acc[15:8]    = b;
      default: ;
    endcase

    if (p >= POS_EEG_FIRST && p <= POS_EEG_LAST) begin
      slot = (int'(p) - int'(POS_EEG_FIRST)) % WIN_LEN;
      if (slot != int'(WIN_EVENT_SLOT)) win_bytes[slot] = b;
      else if (header_ok) sample_due = 1'b1;
    end

    if (last) begin
      // The summary wins over a window that closes on the same byte.
      rec.record_kind = KIND_SUMMARY;
      if (header_ok && p >= POS_MIN_OK) begin
        rec.command_word  = cmd_acc;
        rec.length_word   = len_acc;
        rec.order_number  = order_acc;
        rec.battery_level = battery_acc;
        rec.electrode_off = off_acc;
        rec.gravity_value = gravity_acc;
        rec.check_word    = (p >= POS_CHK_HI) ? check_acc : 16'd0;
        rec.frame_ok      = 1'b1;
      end
      expected_records.push_back(rec);
      clear_frame_state();
    end else begin
      if (byte_pos != POS_MAX) byte_pos = byte_pos + 1'b1;
      if (sample_due) begin
        rec.record_kind = KIND_SAMPLE;
        rec.first_uv    = scale_to_uv({win_bytes[2], win_bytes[1], win_bytes[0]}, gain_first);
        rec.second_uv   = scale_to_uv({win_bytes[5], win_bytes[4], win_bytes[3]}, gain_second);
        rec.event_mark  = b;
        expected_records.push_back(rec);
      end
    end
  endtask

  task automatic show_record(input string tag, input efp_record_t r);
    $display("  %s: kind=%0d uv1=%0d uv2=%0d event=%02h cmd=%04h len=%04h", tag,
             r.record_kind, $signed(r.first_uv), $signed(r.second_uv), r.event_mark,
             r.command_word, r.length_word);
    $display("  %s: order=%06h battery=%04h off=%0d gravity=%06h check=%04h ok=%0d", tag,
             r.order_number, r.battery_level, r.electrode_off, r.gravity_value,
             r.check_word, r.frame_ok);
  endtask

  task automatic check_record();
    efp_record_t got;
    efp_record_t want;
    got.record_kind   = out_mon.record_kind;
    got.first_uv      = out_mon.first_uv;
    got.second_uv     = out_mon.second_uv;
    got.event_mark    = out_mon.event_mark;
    got.command_word  = out_mon.command_word;
    got.length_word   = out_mon.length_word;
    got.order_number  = out_mon.order_number;
    got.battery_level = out_mon.battery_level;
    got.electrode_off = out_mon.electrode_off;
    got.gravity_value = out_mon.gravity_value;
    got.check_word    = out_mon.check_word;
    got.frame_ok      = out_mon.frame_ok;

    if (got.record_kind === KIND_SUMMARY) n_summary++;
    else n_sample++;

    if (expected_records.size() == 0) begin
      if (n_fail < SHOWN_MAX) begin
        $display("[%0t] record beat with nothing expected", $realtime);
        show_record("actual  ", got);
      end
      n_fail++;
    end else begin
      want = expected_records.pop_front();
      if (got !== want) begin
        if (n_fail < SHOWN_MAX) begin
          $display("[%0t] record mismatch", $realtime);
          show_record("expected", want);
          show_record("actual  ", got);
        end
        n_fail++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gain_first  = GAIN_RESET;
      gain_second = GAIN_RESET;
      clear_frame_state();
      expected_records.delete();
      n_fail    = 0;
      n_sample  = 0;
      n_summary = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST_GAIN:  gain_first  = cfg_wdata;
          CFG_SECOND_GAIN: gain_second = cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) parse_frame_byte(in_mon.data_byte, in_mon.last_byte);
      if (out_mon.valid && out_mon.ready) check_record();
    end
    fail_count    <= n_fail;
    pending       <= expected_records.size();
    sample_count  <= n_sample;
    summary_count <= n_summary;
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// EEG frame parser regression
// Feeds directed and random byte frames through the parser under several gain
// settings, with bursty input and stalling output, and lets the record
// checker compare every sample and summary record.
// ----------------------------------------------------------------------------
module tb;
  import efp_pkg::*;

  // The watchdog limit leaves ample room over what a correct run needs, even
  // with a record on every byte under the slowest receiver, before it calls
  // the run hung.
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 120;
  localparam int HOLD_CYCLES   = 2500;
  // Settle time for anything still in flight inside the block.
  localparam int SETTLE_CYCLES = 64;
  localparam int FRAME_MAX     = 300;
  localparam int FULL_FRAME    = 187;
  localparam int WIN_LEN       = 7;
  localparam int WINDOWS       = 10;

  // Directed frames: a lone header byte, a minimal good frame of eight bytes
  // with all-zero and all-one field bytes, the same length with the fourth
  // header byte wrong, and a good header that ends one byte too early.
  localparam logic [7:0] DIRECTED_BYTES [24] = '{
    8'h41,
    8'h41, 8'h49, 8'h52, 8'h90, 8'h00, 8'hFF, 8'h00, 8'hFF,
    8'h41, 8'h49, 8'h52, 8'h91, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h41, 8'h49, 8'h52, 8'h90, 8'h12, 8'h34, 8'h56
  };
  // Bit i set marks directed byte i as the last byte of its frame.
  localparam logic [23:0] DIRECTED_LAST = 24'h810101;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0]    cfg_wdata;

  efp_in_if  in_bus ();
  efp_out_if out_bus ();

  int fail_count;
  int pending;
  int sample_count;
  int summary_count;

  int burst_left  = 0;
  int items_sent  = 0;
  int frames_sent = 0;

  // The stimulus asks for a long receiver hold by bumping hold_asks; the
  // receiver process serves each request once and counts the hold itself.
  int hold_asks   = 0;

  eeg_frame_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_bus),
    .out_chan  (out_bus)
  );

  efp_frame_checker u_frame_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .fail_count    (fail_count),
    .pending       (pending),
    .sample_count  (sample_count),
    .summary_count (summary_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: if the run has not finished by the limit, something is stuck.
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("eeg_frame_parser regression: fail");
    $finish;
  end

  // Receiver. Outside a requested hold it switches between stretches of
  // always ready, coin-flip ready, ready one cycle in four and mostly ready,
  // so that stalls land on every phase of the block's work.
  initial begin
    int hold_served;
    int hold_left;
    int mode;
    int mode_left;
    int tick;
    hold_served = 0;
    hold_left   = 0;
    mode        = 0;
    mode_left   = 0;
    tick        = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (hold_served != hold_asks) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
        out_bus.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        case (mode)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= 1'($urandom_range(0, 1));
          2:       out_bus.ready <= (tick % 4 == 0);
          default: out_bus.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Both gains go in as back-to-back writes, the first gain then the second. The block must be
  // idle, which the caller guarantees by draining first.
  task automatic program_gains(input logic [GAIN_W-1:0] first_gain,
                               input logic [GAIN_W-1:0] second_gain);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIRST_GAIN;
    cfg_wdata <= first_gain;
    @(posedge clk);
    cfg_index <= CFG_SECOND_GAIN;
    cfg_wdata <= second_gain;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // With the sender stopped, wait until every predicted record has been taken,
  // then give the block time to finish work on bytes that cause no record.
  task automatic drain_results();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one byte and hold it until the block takes it. Bytes go out in
  // bursts of random length; between bursts valid drops for a random gap,
  // which is sometimes zero so that long unbroken stretches occur too.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= last;
    do @(posedge clk); while (!in_bus.ready);
    burst_left--;
    items_sent++;
  endtask

  // Raw 24-bit sample content: often one of the full-scale corners or the
  // values around zero, otherwise random.
  function automatic logic [23:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 24'h000000;
      1:       return 24'h7FFFFF;
      2:       return 24'h800000;
      3:       return 24'hFFFFFF;
      4:       return 24'h000001;
      default: return 24'($urandom);
    endcase
  endfunction

  // One frame of the given length. A well-formed frame carries the correct
  // header (now and then with one bit flipped) and EEG windows with chosen
  // sample values; a noise frame is random bytes throughout.
  task automatic send_frame(input int len, input bit noise);
    logic [7:0]  frame_bytes [FRAME_MAX];
    logic [23:0] s1;
    logic [23:0] s2;
    int          base;
    int          bad_pos;
    for (int i = 0; i < FRAME_MAX; i++) frame_bytes[i] = 8'($urandom_range(0, 255));
    if (!noise) begin
      for (int i = 0; i < HDR_LEN; i++) frame_bytes[i] = HDR_BYTES[i];
      if ($urandom_range(0, 7) == 0) begin
        bad_pos = $urandom_range(0, HDR_LEN - 1);
        frame_bytes[bad_pos] ^= 8'(1 << $urandom_range(0, 7));
      end
      for (int w = 0; w < WINDOWS; w++) begin
        base = int'(POS_EEG_FIRST) + WIN_LEN * w;
        s1 = pick_sample();
        s2 = pick_sample();
        frame_bytes[base]     = s1[7:0];
        frame_bytes[base + 1] = s1[15:8];
        frame_bytes[base + 2] = s1[23:16];
        frame_bytes[base + 3] = s2[7:0];
        frame_bytes[base + 4] = s2[15:8];
        frame_bytes[base + 5] = s2[23:16];
      end
      // The electrode-off byte is zero half the time so the flag toggles.
      if ($urandom_range(0, 1) == 0) frame_bytes[POS_OFF] = 8'h00;
    end
    for (int i = 0; i < len; i++) send_byte(frame_bytes[i], i == len - 1);
    frames_sent++;
  endtask

  initial begin
    int  phase_items;
    int  len;
    bit  noise;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_FIRST_GAIN;
    cfg_wdata         = GAIN_RESET;
    in_bus.valid      = 1'b0;
    in_bus.data_byte  = 8'h00;
    in_bus.last_byte  = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames run with the gains left at their reset value.
    for (int i = 0; i < 24; i++) begin
      send_byte(DIRECTED_BYTES[i], DIRECTED_LAST[i]);
      if (DIRECTED_LAST[i]) frames_sent++;
    end

    // Random phases, each under its own gain setting. Every gain change
    // waits for the block to go idle, so each phase starts with the sender
    // paused until every expected record has arrived.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        in_bus.valid <= 1'b0;
        drain_results();
        case (phase)
          1:       program_gains(8'd1, 8'd255);
          2:       program_gains(8'd255, 8'd1);
          3:       program_gains(8'd0, 8'd0);
          4:       program_gains(GAIN_RESET, 8'($urandom_range(1, 255)));
          default: program_gains(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        endcase
      end

      phase_items = items_sent;
      if (phase == 2) begin
        // Hold the receiver off for a long stretch across a full frame so
        // sample records back up and the block stalls its input.
        hold_asks++;
        send_frame(FULL_FRAME, 1'b0);
      end

      while (items_sent - phase_items < PHASE_ITEMS) begin
        noise = 1'b0;
        // Frame lengths: mostly complete frames, plus frames whose last byte
        // closes an EEG window, a frame one byte short of the checksum, long
        // frames that run the position into saturation, short frames and
        // noise.
        case ($urandom_range(0, 15))
          9:  len = int'(POS_EEG_FIRST) + WIN_LEN;
          10: len = int'(POS_EEG_LAST) + 1;
          11: len = FULL_FRAME - 1;
          12: len = 264;
          13: len = $urandom_range(1, 12);
          14: len = $urandom_range(13, 200);
          15: begin
            len   = $urandom_range(1, 40);
            noise = 1'b1;
          end
          default: len = FULL_FRAME;
        endcase
        send_frame(len, noise);
      end
    end

    in_bus.valid <= 1'b0;
    drain_results();

    $display("Run covered %0d input beats in %0d frames, yielding %0d sample records",
             items_sent, frames_sent, sample_count);
    $display("and %0d summaries under %0d gain settings including zero, unity and full-range gains.",
             summary_count, PHASES);
    if (fail_count == 0) begin
      $display("eeg_frame_parser regression: pass");
    end else begin
      $display("eeg_frame_parser regression: fail");
    end
    $finish;
  end

endmodule

/* eeg_frame_parser.f */
src/efp_pkg.sv
src/efp_in_if.sv
src/efp_out_if.sv
src/efp_divider.sv
src/efp_datapath.sv
src/efp_ctrl.sv
src/eeg_frame_parser.sv
src/efp_checker.sv
dv/efp_frame_checker.sv
dv/tb.sv
